// ===== rtl/assert_macros.svh =====
// Assertion macros used by the transform RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, quiet during reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked property, also checked during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ppt_pkg.sv =====
// Package: shared constants and types of the projective point transform
package ppt_pkg;
  localparam int CoordW  = 32;
  localparam int CoefW   = 64;
  localparam int QuotW   = 33;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_X  = 3'd0,
    CFG_ROW_Y  = 3'd1,
    CFG_ROW_W  = 3'd2,
    CFG_OFFSET = 3'd3,
    CFG_W_OFF  = 3'd4
  } cfg_idx_e;
endpackage

// ===== rtl/projective_point_transform.sv =====
// Projective point transform: pipelined 3x3 homography of a Q format 2D point
//
// One point word is taken every cycle while the output word is not stalled, and
// one result word leaves per point, in order. The depth is set by the two
// restoring dividers, one quotient bit per pipeline stage; a multiply stage, a
// sum stage and a range-check stage come first and a saturation stage last.
// The whole pipe holds when the output word is stalled.
// Configuration is taken at any time and used by points accepted afterwards.
module projective_point_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ppt_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [ppt_pkg::CoefW-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [ppt_pkg::CoordW-1:0]   point_x_i,
  input  logic signed [ppt_pkg::CoordW-1:0]   point_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ppt_pkg::CoordW-1:0]   mapped_x_o,
  output logic signed [ppt_pkg::CoordW-1:0]   mapped_y_o,
  output logic                                range_fault_o
);
  import ppt_pkg::*;
  `include "assert_macros.svh"

  localparam int PW  = 2 * CoordW;
  localparam int SW  = PW + 2;
  localparam int NNW = SW + FRAC_BITS;
  localparam int CW  = NNW + QuotW;

  localparam logic [CoordW-1:0] One   = CoordW'(1) << FRAC_BITS;
  localparam logic [CoordW-1:0] MaxV  = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] MinV  = {1'b1, {(CoordW-1){1'b0}}};

  typedef struct packed {
    logic          sx;
    logic          sy;
    logic          sd;
    logic          dz;
    logic          ovx;
    logic          ovy;
    logic [NNW-1:0] nx;
    logic [NNW-1:0] ny;
    logic [SW-1:0]  d;
    logic [SW-1:0]  rx;
    logic [SW-1:0]  ry;
    logic [QuotW-1:0] qx;
    logic [QuotW-1:0] qy;
  } div_t;

  // configuration
  logic [CoefW-1:0]  row_x_q, row_y_q, row_w_q, off_q;
  logic [CoordW-1:0] w_off_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_q <= {{CoordW{1'b0}}, One};
      row_y_q <= {One, {CoordW{1'b0}}};
      row_w_q <= '0;
      off_q   <= '0;
      w_off_q <= One;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROW_X:  row_x_q <= cfg_data_i;
        CFG_ROW_Y:  row_y_q <= cfg_data_i;
        CFG_ROW_W:  row_w_q <= cfg_data_i;
        CFG_OFFSET: off_q   <= cfg_data_i;
        CFG_W_OFF:  w_off_q <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v_q;
  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: products and scaled offsets
  logic               v1_q;
  logic signed [PW-1:0] p_xa_q, p_yb_q, p_xc_q, p_yd_q, p_xe_q, p_yf_q;
  logic signed [SW-1:0] o_x_q, o_y_q, o_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_xa_q <= point_x_i * $signed(row_x_q[CoordW-1:0]);
      p_yb_q <= point_y_i * $signed(row_x_q[PW-1:CoordW]);
      p_xc_q <= point_x_i * $signed(row_y_q[CoordW-1:0]);
      p_yd_q <= point_y_i * $signed(row_y_q[PW-1:CoordW]);
      p_xe_q <= point_x_i * $signed(row_w_q[CoordW-1:0]);
      p_yf_q <= point_y_i * $signed(row_w_q[PW-1:CoordW]);
      o_x_q  <= SW'($signed(off_q[CoordW-1:0])) <<< FRAC_BITS;
      o_y_q  <= SW'($signed(off_q[PW-1:CoordW])) <<< FRAC_BITS;
      o_w_q  <= SW'($signed(w_off_q)) <<< FRAC_BITS;
    end
  end

  // stage 2: row sums, magnitudes, signs and zero-w flag
  logic signed [SW-1:0] s_x, s_y, s_w;
  logic               v2_q, snx_q, sny_q, sdw_q, dz_q;
  logic [SW-1:0]      mx_q, my_q, md_q;

  assign s_x = SW'(p_xa_q) + SW'(p_yb_q) + o_x_q;
  assign s_y = SW'(p_xc_q) + SW'(p_yd_q) + o_y_q;
  assign s_w = SW'(p_xe_q) + SW'(p_yf_q) + o_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      snx_q <= s_x[SW-1];
      sny_q <= s_y[SW-1];
      sdw_q <= s_w[SW-1];
      dz_q  <= (s_w == '0);
      mx_q  <= s_x[SW-1] ? SW'(-s_x) : SW'(s_x);
      my_q  <= s_y[SW-1] ? SW'(-s_y) : SW'(s_y);
      md_q  <= s_w[SW-1] ? SW'(-s_w) : SW'(s_w);
    end
  end

  // stage 3: scale numerators, range check, first partial remainder
  logic [NNW-1:0] n_x, n_y;
  logic [CW-1:0]  d_big;
  logic [QuotW:0] dv_q;
  div_t           dv_q_arr [QuotW+1];
  div_t           d_in;

  assign n_x   = {mx_q, {FRAC_BITS{1'b0}}};
  assign n_y   = {my_q, {FRAC_BITS{1'b0}}};
  assign d_big = {{FRAC_BITS{1'b0}}, md_q, {QuotW{1'b0}}};

  always_comb begin
    d_in     = '0;
    d_in.sx  = snx_q;
    d_in.sy  = sny_q;
    d_in.sd  = sdw_q;
    d_in.dz  = dz_q;
    d_in.ovx = ({{QuotW{1'b0}}, n_x} >= d_big);
    d_in.ovy = ({{QuotW{1'b0}}, n_y} >= d_big);
    d_in.nx  = n_x;
    d_in.ny  = n_y;
    d_in.d   = md_q;
    d_in.rx  = SW'(n_x[NNW-1:QuotW]);
    d_in.ry  = SW'(n_y[NNW-1:QuotW]);
  end

  // valid bits of the range-check and divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= '0;
    else if (en) dv_q <= {dv_q[QuotW-1:0], v2_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) dv_q_arr[0] <= d_in;
  end

  // restoring divide, one quotient bit per stage, MSB first
  for (genvar i = 0; i < QuotW; i++) begin : g_div
    localparam int K = QuotW - 1 - i;
    logic [SW:0] tx, ty;
    logic        gx, gy;
    div_t        nxt;

    always_comb begin
      nxt   = dv_q_arr[i];
      tx    = {dv_q_arr[i].rx, dv_q_arr[i].nx[K]};
      ty    = {dv_q_arr[i].ry, dv_q_arr[i].ny[K]};
      gx    = (tx >= {1'b0, dv_q_arr[i].d});
      gy    = (ty >= {1'b0, dv_q_arr[i].d});
      nxt.rx = gx ? SW'(tx - {1'b0, dv_q_arr[i].d}) : tx[SW-1:0];
      nxt.ry = gy ? SW'(ty - {1'b0, dv_q_arr[i].d}) : ty[SW-1:0];
      nxt.qx[K] = gx;
      nxt.qy[K] = gy;
    end

    always_ff @(posedge clk_i) begin
      if (en) dv_q_arr[i+1] <= nxt;
    end
  end

  // final stage: sign, saturation, zero divisor
  div_t             fin;
  logic             negx, negy, fx, fy;
  logic [CoordW-1:0] rx_d, ry_d;
  logic [CoordW-1:0] out_x_q, out_y_q;
  logic             fault_d, fault_q;

  assign fin  = dv_q_arr[QuotW];
  assign negx = fin.sx ^ fin.sd;
  assign negy = fin.sy ^ fin.sd;

  always_comb begin
    if (fin.dz) begin
      fx   = 1'b1;
      rx_d = (fin.nx == '0) ? '0 : (fin.sx ? MinV : MaxV);
    end else if (negx) begin
      fx   = fin.ovx || fin.qx[QuotW-1] ||
             (fin.qx[CoordW-1] && (fin.qx[CoordW-2:0] != '0));
      rx_d = fx ? MinV : CoordW'(-fin.qx[CoordW-1:0]);
    end else begin
      fx   = fin.ovx || fin.qx[QuotW-1] || fin.qx[CoordW-1];
      rx_d = fx ? MaxV : fin.qx[CoordW-1:0];
    end
  end

  always_comb begin
    if (fin.dz) begin
      fy   = 1'b1;
      ry_d = (fin.ny == '0) ? '0 : (fin.sy ? MinV : MaxV);
    end else if (negy) begin
      fy   = fin.ovy || fin.qy[QuotW-1] ||
             (fin.qy[CoordW-1] && (fin.qy[CoordW-2:0] != '0));
      ry_d = fy ? MinV : CoordW'(-fin.qy[CoordW-1:0]);
    end else begin
      fy   = fin.ovy || fin.qy[QuotW-1] || fin.qy[CoordW-1];
      ry_d = fy ? MaxV : fin.qy[CoordW-1:0];
    end
  end

  assign fault_d = fx || fy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= dv_q[QuotW];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q <= rx_d;
      out_y_q <= ry_d;
      fault_q <= fault_d;
    end
  end

  assign out_valid_o   = out_v_q;
  assign mapped_x_o    = $signed(out_x_q);
  assign mapped_y_o    = $signed(out_y_q);
  assign range_fault_o = fault_q;

  `ASSERT_CLK(a_zero_w_faults, clk_i, rst_ni,
    en && dv_q[QuotW] && fin.dz |=> range_fault_o, "zero w without fault")
  `ASSERT_CLK(a_hold_on_stall, clk_i, rst_ni,
    !en |=> $stable(dv_q) && $stable(v2_q) && $stable(v1_q), "pipe moved while held")
  `ASSERT_CLK(a_sat_on_overflow, clk_i, rst_ni,
    en && dv_q[QuotW] && fin.ovx && !fin.dz |=> range_fault_o, "overflow not flagged")
endmodule

// ===== tb/tb_projective_point_transform.sv =====
// Testbench for the projective point transform: random and directed points against a predictor
module tb_projective_point_transform;
  timeunit 1ns;
  timeprecision 1ps;
  import ppt_pkg::*;

  localparam int FRAC_BITS_TB = 16;
  localparam int LatencyCycles = QuotW + 4;
  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareC = 3'd7;
  localparam logic [31:0] OneQ = 32'h0001_0000;
  localparam logic [31:0] MaxQ = 32'h7FFF_FFFF;
  localparam logic [31:0] MinQ = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] mx;
    logic [31:0] my;
    logic        fault;
  } mapped_t;

  class homography_scoreboard;
    logic [63:0] row_x, row_y, row_w, offs;
    logic [31:0] w22;
    mapped_t     expected_q[$];
    int          errors;
    int          points_in;
    int          points_out;
    int          faults_seen;

    function new();
      row_x = {32'd0, OneQ};
      row_y = {OneQ, 32'd0};
      row_w = '0;
      offs  = '0;
      w22   = OneQ;
      errors = 0;
      points_in = 0;
      points_out = 0;
      faults_seen = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
      case (idx)
        CFG_ROW_X:  row_x = data;
        CFG_ROW_Y:  row_y = data;
        CFG_ROW_W:  row_w = data;
        CFG_OFFSET: offs  = data;
        CFG_W_OFF:  w22   = data[31:0];
        default: ;
      endcase
    endfunction

    function logic signed [127:0] row_sum(logic signed [127:0] xs, logic signed [127:0] ys,
                                          logic [63:0] coefs, logic [31:0] off);
      logic signed [127:0] a, b, o;
      a = $signed(coefs[31:0]);
      b = $signed(coefs[63:32]);
      o = $signed(off);
      return xs * a + ys * b + (o <<< FRAC_BITS_TB);
    endfunction

    function void divide_sat(logic signed [127:0] n, logic signed [127:0] d,
                             output logic [31:0] res, output logic fault);
      logic [127:0] nm, dm, q;
      logic neg;
      fault = 1'b0;
      if (d == 0) begin
        fault = 1'b1;
        res = (n == 0) ? 32'd0 : (n < 0) ? MinQ : MaxQ;
      end else begin
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        q = (nm << FRAC_BITS_TB) / dm;
        neg = (n < 0) != (d < 0);
        if (neg) begin
          if (q > 128'h8000_0000) begin
            res = MinQ;
            fault = 1'b1;
          end else begin
            res = 32'd0 - q[31:0];
          end
        end else begin
          if (q > 128'h7FFF_FFFF) begin
            res = MaxQ;
            fault = 1'b1;
          end else begin
            res = q[31:0];
          end
        end
      end
    endfunction

    function void note_point(logic [31:0] x, logic [31:0] y);
      logic signed [127:0] xs, ys, nx, ny, w;
      logic fx, fy;
      mapped_t e;
      xs = $signed(x);
      ys = $signed(y);
      nx = row_sum(xs, ys, row_x, offs[31:0]);
      ny = row_sum(xs, ys, row_y, offs[63:32]);
      w  = row_sum(xs, ys, row_w, w22);
      divide_sat(nx, w, e.mx, fx);
      divide_sat(ny, w, e.my, fy);
      e.fault = fx | fy;
      expected_q.push_back(e);
      points_in++;
    endfunction

    function void check_result(logic [31:0] mx, logic [31:0] my, logic fault);
      mapped_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: x=%h y=%h fault=%b", mx, my, fault);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      points_out++;
      if (fault) faults_seen++;
      if (mx !== e.mx) begin
        $error("mapped_x: expected %h actual %h", e.mx, mx);
        errors++;
      end
      if (my !== e.my) begin
        $error("mapped_y: expected %h actual %h", e.my, my);
        errors++;
      end
      if (fault !== e.fault) begin
        $error("range_fault: expected %b actual %b", e.fault, fault);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CoefW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CoordW-1:0] point_x_i = '0;
  logic signed [CoordW-1:0] point_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [CoordW-1:0] mapped_x_o;
  logic signed [CoordW-1:0] mapped_y_o;
  logic range_fault_o;

  homography_scoreboard sb = new();
  int hold_requests = 0;
  int holds_served = 0;
  int regs_written = 0;

  always #5 clk_i = ~clk_i;

  projective_point_transform #(.FRAC_BITS(FRAC_BITS_TB)) uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .point_x_i, .point_y_i,
    .out_valid_o, .out_stall_i, .mapped_x_o, .mapped_y_o, .range_fault_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_point(point_x_i, point_y_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(mapped_x_o, mapped_y_o, range_fault_o);
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // receiver: random stalls, long hold-off on request, quiet stretches
  initial begin : receiver
    int hold_left, quiet_left;
    hold_left = 0;
    quiet_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = 300;
        out_stall_i <= 1'b1;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_stall_i <= 1'b0;
      end else begin
        hold_left = idle_len();
        if (hold_left == 0) quiet_left = $urandom_range(40);
        out_stall_i <= (hold_left > 0);
        if (hold_left > 0) hold_left--;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    regs_written++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, bit no_gap);
    int g;
    in_valid_i <= 1'b1;
    point_x_i  <= x;
    point_y_i  <= y;
    do @(posedge clk_i); while (in_stall_o);
    g = no_gap ? 0 : idle_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g - 1) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (LatencyCycles + 5) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(9);
    case (r)
      0: return MaxQ;
      1: return MinQ;
      2, 3: return $urandom_range(20 * OneQ) - 10 * OneQ;
      4: return $urandom_range(OneQ) - OneQ / 2;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    int r;
    r = $urandom_range(7);
    case (r)
      0: return MaxQ;
      1: return MinQ;
      2: return 32'd0;
      3, 4: return $urandom_range(4 * OneQ) - 2 * OneQ;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_points(int n);
    bit burst;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) burst = $urandom_range(3) == 0;
      send_point(rand_coord(), rand_coord(), burst);
    end
  endtask

  task automatic random_config(bit perspective);
    write_reg(CFG_ROW_X, {rand_coef(), rand_coef()});
    write_reg(CFG_ROW_Y, {rand_coef(), rand_coef()});
    if (perspective)
      write_reg(CFG_ROW_W, {32'($urandom_range(512)) - 256, 32'($urandom_range(512)) - 256});
    else
      write_reg(CFG_ROW_W, {rand_coef(), rand_coef()});
    write_reg(CFG_OFFSET, {rand_coef(), rand_coef()});
    write_reg(CFG_W_OFF, {32'($urandom), rand_coef()});
  endtask

  initial begin : stimulus
    logic [31:0] edge_vals [6];
    edge_vals = '{32'd0, MaxQ, MinQ, OneQ, 32'hFFFF_FFFF, 32'h0000_0001};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity after reset: extremes of both coordinates
    for (int i = 0; i < 6; i++) send_point(edge_vals[i], edge_vals[5 - i], 1'b0);
    drain();

    // zero w: saturate on sign of the numerator
    write_reg(CFG_W_OFF, 64'd0);
    write_reg(CFG_OFFSET, {MinQ, MaxQ});
    send_point(32'd0, 32'd0, 1'b0);
    send_point(OneQ, 32'd0, 1'b0);
    send_point(MinQ, MaxQ, 1'b0);
    drain();
    write_reg(CFG_OFFSET, 64'd0);
    send_point(32'd0, 32'd0, 1'b0);
    send_point(MaxQ, MinQ, 1'b0);
    drain();

    // quotient overflow and unused high bits of the w constant
    write_reg(CFG_ROW_X, {MaxQ, MaxQ});
    write_reg(CFG_ROW_Y, {MinQ, MinQ});
    write_reg(CFG_W_OFF, {32'hDEAD_BEEF, 32'h0000_0001});
    send_point(MaxQ, MaxQ, 1'b0);
    send_point(MinQ, MinQ, 1'b0);
    send_point(OneQ, 32'hFFFF_0000, 1'b0);
    // spare indexes must leave the map alone
    drain();
    write_reg(CfgSpareA, 64'd0);
    write_reg(CfgSpareB, '1);
    write_reg(CfgSpareC, 64'd0);
    write_reg(CFG_W_OFF, {32'd0, MinQ});
    send_point(32'd0, 32'd0, 1'b0);
    send_point(MaxQ, 32'd1, 1'b0);
    drain();

    // long receiver hold-off while points keep coming
    hold_requests++;
    random_points(120);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      random_config(ph % 2 == 0);
      if (ph == 5) hold_requests++;
      random_points(120);
      drain();
    end

    $display("%0d points sent, %0d checked, %0d with range fault, %0d register writes",
             sb.points_in, sb.points_out, sb.faults_seen, regs_written);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #3ms;
    $display("Verification failed");
    $finish;
  end
endmodule

// ===== projective_point_transform.f =====
+incdir+rtl
rtl/ppt_pkg.sv
rtl/projective_point_transform.sv
tb/tb_projective_point_transform.sv
